// File: sv/mv2_pkg.sv
`default_nettype none
package mv2_pkg;

    localparam int NBITS     = 100;
    localparam int KEY_BITS  = 80;
    localparam int MIX_ZEROS = 100;
    localparam int BYTE_BITS = 8;

    // input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW   = 2'd1;
    localparam logic [1:0] CFG_IV_LENGTH = 2'd2;

    localparam logic [6:0] IV_LEN_RESET = 7'd80;
    localparam logic [6:0] IV_LEN_MAX   = 7'd80;

    // R feedback taps, S comp and feedback masks
    localparam logic [NBITS-1:0] RTAPS = {36'h3df87818f, 64'hb55466601279327b};
    localparam logic [NBITS-1:0] COMP0 = {36'h6057ebfea, 64'h7942a8096aa97a30};
    localparam logic [NBITS-1:0] COMP1 = {36'h191c23dd7, 64'he3a21d63dd629e9a};
    localparam logic [NBITS-1:0] FB0   = {36'h19cec5802, 64'haf4a93819ffa7faf};
    localparam logic [NBITS-1:0] FB1   = {36'h840fbc52b, 64'h4911b0634c8cb877};
    // comp term only acts on bits 1..98
    localparam logic [NBITS-1:0] MIX_MASK = {1'b0, {(NBITS-2){1'b1}}, 1'b0};

    typedef struct packed {
        logic en;   // clock the generator once
        logic clr;  // zero both registers
        logic mix;  // mixing mode
        logic din;  // input bit
    } t_step;

endpackage
`default_nettype wire

// File: sv/mv2_cell.sv
`default_nettype none
module mv2_cell (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire mv2_pkg::t_step i_step,
    input  wire          i_r_prev,
    input  wire          i_s_prev,
    input  wire          i_s_next,
    input  wire          i_fb_r,
    input  wire          i_fb_s,
    input  wire          i_ctl_r,
    input  wire          i_ctl_s,
    input  wire          i_rt,
    input  wire          i_c0,
    input  wire          i_c1,
    input  wire          i_f0,
    input  wire          i_f1,
    input  wire          i_mix_on,
    output logic         o_r,
    output logic         o_s
);

    logic r_rbit, r_sbit;
    logic n_rbit, n_sbit;

    always_comb begin
        n_rbit = i_r_prev ^ (i_ctl_r & r_rbit) ^ (i_fb_r & i_rt);
        n_sbit = i_s_prev
               ^ (i_mix_on & (r_sbit ^ i_c0) & (i_s_next ^ i_c1))
               ^ (i_fb_s & (i_ctl_s ? i_f1 : i_f0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_step.clr) begin
            r_rbit <= 1'b0;
            r_sbit <= 1'b0;
        end else if (i_step.en) begin
            r_rbit <= n_rbit;
            r_sbit <= n_sbit;
        end
    end

    assign o_r = r_rbit;
    assign o_s = r_sbit;

endmodule
`default_nettype wire

// File: sv/mv2_chain.sv
`default_nettype none
module mv2_chain (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire mv2_pkg::t_step i_step,
    output logic           o_z
);

    localparam int N = mv2_pkg::NBITS;

    logic [N-1:0] w_r, w_s;
    logic [N-1:0] w_r_prev, w_s_prev, w_s_next;
    logic         w_fb_r, w_fb_s, w_ctl_r, w_ctl_s;

    assign w_r_prev = {w_r[N-2:0], 1'b0};
    assign w_s_prev = {w_s[N-2:0], 1'b0};
    assign w_s_next = {1'b0, w_s[N-1:1]};

    assign w_ctl_r = w_s[34] ^ w_r[67];
    assign w_ctl_s = w_r[33] ^ w_s[67];
    assign w_fb_r  = w_r[N-1] ^ i_step.din ^ (i_step.mix & w_s[50]);
    assign w_fb_s  = w_s[N-1] ^ i_step.din;
    assign o_z     = w_r[0] ^ w_s[0];

    for (genvar g = 0; g < N; g++) begin : g_cell
        mv2_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (i_step),
            .i_r_prev (w_r_prev[g]),
            .i_s_prev (w_s_prev[g]),
            .i_s_next (w_s_next[g]),
            .i_fb_r   (w_fb_r),
            .i_fb_s   (w_fb_s),
            .i_ctl_r  (w_ctl_r),
            .i_ctl_s  (w_ctl_s),
            .i_rt     (mv2_pkg::RTAPS[g]),
            .i_c0     (mv2_pkg::COMP0[g]),
            .i_c1     (mv2_pkg::COMP1[g]),
            .i_f0     (mv2_pkg::FB0[g]),
            .i_f1     (mv2_pkg::FB1[g]),
            .i_mix_on (mv2_pkg::MIX_MASK[g]),
            .o_r      (w_r[g]),
            .o_s      (w_s[g])
        );
    end

endmodule
`default_nettype wire

// File: sv/mv2_ctrl.sv
`default_nettype none
module mv2_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire  [79:0]     i_key,
    input  wire  [6:0]      i_iv_length,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  wire             i_op,
    input  wire  [79:0]     i_iv,
    input  wire  [7:0]      i_data_in,
    input  wire             i_last_of_message,
    input  wire             i_z,
    output mv2_pkg::t_step  o_step,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output logic [7:0]      o_data_out,
    output logic            o_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_IV   = 3'd1;
    localparam logic [2:0] ST_KEY  = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    localparam logic [6:0] KEY_LAST  = 7'(mv2_pkg::KEY_BITS - 1);
    localparam logic [6:0] ZERO_LAST = 7'(mv2_pkg::MIX_ZEROS - 1);
    localparam logic [6:0] BYTE_LAST = 7'(mv2_pkg::BYTE_BITS - 1);

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic [79:0] r_sh, n_sh;
    logic [7:0]  r_ks, n_ks;
    logic [7:0]  r_dat, n_dat;
    logic        r_lst, n_lst;
    logic        r_o_valid, n_o_valid;
    logic [7:0]  r_o_data, n_o_data;
    logic        r_o_last, n_o_last;

    logic        w_acc, w_out_free;
    logic [6:0]  w_iv_n;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_acc      = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_o_valid | ~i_out_stall;
    assign w_iv_n     = (i_iv_length > mv2_pkg::IV_LEN_MAX) ? mv2_pkg::IV_LEN_MAX
                                                             : i_iv_length;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_sh      = r_sh;
        n_ks      = r_ks;
        n_dat     = r_dat;
        n_lst     = r_lst;
        n_o_valid = r_o_valid & i_out_stall;
        n_o_data  = r_o_data;
        n_o_last  = r_o_last;
        o_step    = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_cnt = '0;
                    if (i_op == mv2_pkg::OP_START) begin
                        o_step.clr = 1'b1;
                        if (w_iv_n == '0) begin
                            n_sh    = i_key;
                            n_state = ST_KEY;
                        end else begin
                            n_sh    = i_iv;
                            n_state = ST_IV;
                        end
                    end else begin
                        n_dat   = i_data_in;
                        n_lst   = i_last_of_message;
                        n_state = ST_DATA;
                    end
                end
            end
            ST_IV: begin
                o_step.en  = 1'b1;
                o_step.mix = 1'b1;
                o_step.din = r_sh[79];
                n_sh       = {r_sh[78:0], 1'b0};
                n_cnt      = r_cnt + 7'd1;
                if (r_cnt == w_iv_n - 7'd1) begin
                    n_sh    = i_key;
                    n_cnt   = '0;
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                o_step.en  = 1'b1;
                o_step.mix = 1'b1;
                o_step.din = r_sh[79];
                n_sh       = {r_sh[78:0], 1'b0};
                n_cnt      = r_cnt + 7'd1;
                if (r_cnt == KEY_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                o_step.en  = 1'b1;
                o_step.mix = 1'b1;
                n_cnt      = r_cnt + 7'd1;
                if (r_cnt == ZERO_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DATA: begin
                // first keystream bit ends up in bit 7
                o_step.en = 1'b1;
                n_ks      = {r_ks[6:0], i_z};
                n_cnt     = r_cnt + 7'd1;
                if (r_cnt == BYTE_LAST) begin
                    if (w_out_free) begin
                        n_o_valid = 1'b1;
                        n_o_data  = r_dat ^ n_ks;
                        n_o_last  = r_lst;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = r_dat ^ r_ks;
                    n_o_last  = r_lst;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh     <= n_sh;
        r_ks     <= n_ks;
        r_dat    <= n_dat;
        r_lst    <= n_lst;
        r_o_data <= n_o_data;
        r_o_last <= n_o_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_data_out  = r_o_data;
    assign o_last      = r_o_last;

endmodule
`default_nettype wire

// File: sv/mickey_v2_stream_cipher_unit.sv
`default_nettype none
// MICKEY 2.0 (80-bit key) keystream unit.
// Input channel (i_in_valid / o_in_stall): a word with i_op = start loads the
// IV (i_iv_high, i_iv_low), clears R and S and runs the key setup; it gives
// no result. A word with i_op = data XORs i_data_in with the next eight
// keystream bits (first bit into bit 7) and returns it on o_data_out with
// o_last copied from i_last_of_message.
// Output channel (o_out_valid / i_out_stall): one registered result word.
// The generator is a row of 100 bit cells clocked once per keystream bit. A
// data word is stepped for its eight keystream bits after acceptance; its
// result enters the output register, once free, as the unit returns to idle.
// A start word keeps the input stalled while the IV bits (iv_length, capped
// at 80), key bits and zero-input mixing steps run. Only one word is in work
// at a time; o_in_stall is high from the cycle after acceptance until done.
// If the receiver stalls, a finished byte waits in the output register and a
// second one waits inside the unit; the input stays stalled until it moves.
// Config port (i_cfg_valid / o_cfg_ready, always ready): index 0 key_high,
// 1 key_low, 2 iv_length; new values apply at the next start word if the
// user writes them while idle; the block does not enforce this. Synchronous
// reset clears R, S and the control state, key to zero and iv_length to 80.
module mickey_v2_stream_cipher_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_op,
    input  wire  [15:0] i_iv_high,
    input  wire  [63:0] i_iv_low,
    input  wire  [7:0]  i_data_in,
    input  wire         i_last_of_message,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_data_out,
    output logic        o_last
);

    logic [15:0]    r_key_high;
    logic [63:0]    r_key_low;
    logic [6:0]     r_iv_length;
    mv2_pkg::t_step w_step;
    logic           w_z;
    logic           w_in_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_iv_length <= mv2_pkg::IV_LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mv2_pkg::CFG_KEY_HIGH:  r_key_high  <= i_cfg_data[15:0];
                mv2_pkg::CFG_KEY_LOW:   r_key_low   <= i_cfg_data;
                mv2_pkg::CFG_IV_LENGTH: r_iv_length <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    mv2_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_key             ({r_key_high, r_key_low}),
        .i_iv_length       (r_iv_length),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_iv              ({i_iv_high, i_iv_low}),
        .i_data_in         (i_data_in),
        .i_last_of_message (i_last_of_message),
        .i_z               (w_z),
        .o_step            (w_step),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_data_out        (o_data_out),
        .o_last            (o_last)
    );

    mv2_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_z     (w_z)
    );

    assign w_in_acc = i_in_valid & ~o_in_stall;

    // an accepted word keeps the input stalled while it is in work
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after accept");

    a_busy_7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##7 o_in_stall)
        else $error("word finished too early");

    // a start word never produces a result
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_op == mv2_pkg::OP_START) |=> !$rose(o_out_valid))
        else $error("result after start word");

    // nothing is generated while the unit is idle
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step.en |-> o_in_stall)
        else $error("generator clocked while idle");

endmodule
`default_nettype wire
